// File: sv/dae_pkg.sv
// Shared types, codes and helpers of the DCTCP alpha estimator.
// No dependencies; every other file refers to it by scoped names.
package dae_pkg;

    // Q1.16 one, divider length and config port widths
    localparam int unsigned ONE_Q16    = 65536;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 17;

    // Step count of the last divider cycle
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EWMA_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSS         = 1'b1;

    // Reset values of the configuration registers
    localparam logic [16:0] EWMA_RESET = 17'd4096;
    localparam logic [15:0] MSS_RESET  = 16'd536;

    // Event kinds
    typedef enum logic [1:0] {
        OP_ACK  = 2'd0,
        OP_SENT = 2'd1,
        OP_RETX = 2'd2
    } t_op;

    // Input item
    typedef struct packed {
        t_op         op;
        logic [31:0] ack_number;
        logic [31:0] prior_ack_mark;
        logic        ece_flag;
        logic        syn_flag;
        logic [31:0] segment_seq;
        logic [15:0] segment_bytes;
        logic [31:0] high_tx_mark;
        logic [31:0] next_tx_seq;
        logic [31:0] cwnd_bytes;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [16:0] alpha_out;
        logic [31:0] ssthresh_out;
        logic        alpha_updated;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic mul_a;
        logic mul_b;
        logic alpha_fin;
        logic ss_mul;
        logic ss_fin;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_alpha;
        logic out_free;
    } t_sts;

    // Wrapping sequence order: a after b
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: sv/dae_ctrl.sv
// Sequencing state machine of the DCTCP alpha estimator.
// Depends on dae_pkg for command and status structs.
module dae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  dae_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output dae_pkg::t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_EVAL   = 9'b0_0000_0010,
        S_DIV    = 9'b0_0000_0100,
        S_MUL_A  = 9'b0_0000_1000,
        S_MUL_B  = 9'b0_0001_0000,
        S_ALPHA  = 9'b0_0010_0000,
        S_SS_MUL = 9'b0_0100_0000,
        S_SS_FIN = 9'b0_1000_0000,
        S_DONE   = 9'b1_0000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [dae_pkg::DIV_CNT_W-1:0]  r_step, n_step;
    logic                           accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and divider step count
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_sts.need_alpha ? S_DIV : S_SS_MUL;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == dae_pkg::DIV_LAST) begin
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A:  n_state = S_MUL_B;
            S_MUL_B:  n_state = S_ALPHA;
            S_ALPHA:  n_state = S_SS_MUL;
            S_SS_MUL: n_state = S_SS_FIN;
            S_SS_FIN: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Decode commands from state
    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = accept;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul_a     = (r_state == S_MUL_A);
        o_cmd.mul_b     = (r_state == S_MUL_B);
        o_cmd.alpha_fin = (r_state == S_ALPHA);
        o_cmd.ss_mul    = (r_state == S_SS_MUL);
        o_cmd.ss_fin    = (r_state == S_SS_FIN);
        o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated next cycle");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_A) |-> $past(r_state == S_DIV)
            && ($past(r_step) == dae_pkg::DIV_LAST))
        else $error("divider left before its last step");

endmodule

// File: sv/dae_dpath.sv
// Datapath of the DCTCP alpha estimator: state, divider, shared multiplier,
// config registers and result register. Depends on dae_pkg.
module dae_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dae_pkg::t_in_item                i_in_data,
    input  logic                             i_cfg_valid,
    input  logic [dae_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dae_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  dae_pkg::t_cmd                    i_cmd,
    input  logic                             i_out_ready,
    output dae_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output dae_pkg::t_out_item               o_out_data
);

    localparam logic [16:0] ONE = 17'(dae_pkg::ONE_Q16);

    // Config registers
    logic [16:0] r_ewma;
    logic [15:0] r_mss;

    // Estimator state
    logic [16:0] r_alpha;
    logic [31:0] r_marked, r_total, r_barrier, r_highest;

    // Item and working registers
    dae_pkg::t_in_item r_item;
    logic        r_upd;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [15:0] r_q;
    logic        r_frac_sat;
    logic [48:0] r_prod;
    logic [33:0] r_acc;
    logic [31:0] r_ss;

    // Result register
    logic               r_out_valid;
    dae_pkg::t_out_item r_out;

    // Evaluation of the captured event
    logic [31:0] d_ack, tot_n, mk_n, dvs_n, sent_end, hs_a, hs_n;
    logic        d_ok, need_alpha;
    logic [16:0] g_c, g_inv, frac;

    always_comb begin
        d_ack = r_item.ack_number - r_item.prior_ack_mark;
        d_ok  = (d_ack != 32'd0) && !d_ack[31];
        tot_n = d_ok ? dae_pkg::sat_add(r_total, d_ack) : r_total;
        mk_n  = (d_ok && r_item.ece_flag) ? dae_pkg::sat_add(r_marked, d_ack) : r_marked;
        dvs_n = (tot_n == 32'd0) ? 32'd1 : tot_n;
        need_alpha = (r_item.op == dae_pkg::OP_ACK) && !r_item.syn_flag
                     && dae_pkg::seq_after(r_item.ack_number, r_barrier);
        sent_end = r_item.segment_seq + {16'd0, r_item.segment_bytes};
        hs_a = dae_pkg::seq_after(r_item.high_tx_mark, sent_end) ? r_item.high_tx_mark
                                                                   : sent_end;
        hs_n = dae_pkg::seq_after(r_highest, hs_a) ? r_highest : hs_a;
        g_c   = (r_ewma > ONE) ? ONE : r_ewma;
        g_inv = ONE - g_c;
        frac  = r_frac_sat ? ONE : {1'b0, r_q};
    end

    // Divider step: restoring, one quotient bit per cycle
    logic [32:0] rem2;
    logic        ge;
    assign rem2 = {r_rem[31:0], 1'b0};
    assign ge   = rem2 >= {1'b0, r_dvs};

    // Shared multiplier operand select
    logic [16:0] mul_x;
    logic [31:0] mul_y;
    always_comb begin
        mul_x = r_alpha;
        mul_y = r_item.cwnd_bytes;
        if (i_cmd.mul_a) begin
            mul_x = g_inv;
            mul_y = {15'd0, r_alpha};
        end else if (i_cmd.mul_b) begin
            mul_x = g_c;
            mul_y = {15'd0, frac};
        end
    end

    // Alpha blend with rounding and cap
    logic [34:0] acc_sum;
    logic [18:0] alpha_sh;
    logic [16:0] alpha_n;
    assign acc_sum  = {1'b0, r_acc} + {1'b0, r_prod[33:0]} + 35'd32768;
    assign alpha_sh = acc_sum[34:16];
    assign alpha_n  = (alpha_sh > {2'b00, ONE}) ? ONE : alpha_sh[16:0];

    // Slow-start threshold from alpha*cwnd
    logic [49:0] red_sum;
    logic [31:0] red, wnd, flo;
    assign red_sum = {1'b0, r_prod} + 50'd131071;
    assign red     = red_sum[48:17];
    assign wnd     = r_item.cwnd_bytes - red;
    assign flo     = {15'd0, r_mss, 1'b0};

    assign o_sts.need_alpha = need_alpha;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

    // Control state: config, estimator state, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ewma      <= dae_pkg::EWMA_RESET;
            r_mss       <= dae_pkg::MSS_RESET;
            r_alpha     <= ONE;
            r_marked    <= '0;
            r_total     <= '0;
            r_barrier   <= '0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dae_pkg::CFG_EWMA_WEIGHT: r_ewma <= i_cfg_data;
                    dae_pkg::CFG_MSS:         r_mss  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                case (r_item.op)
                    dae_pkg::OP_ACK: begin
                        if (!r_item.syn_flag) begin
                            if (need_alpha) begin
                                r_barrier <= r_highest;
                                r_total   <= '0;
                                r_marked  <= '0;
                            end else begin
                                r_total   <= tot_n;
                                r_marked  <= mk_n;
                            end
                        end
                    end
                    dae_pkg::OP_SENT: r_highest <= hs_n;
                    dae_pkg::OP_RETX: begin
                        r_barrier <= r_item.next_tx_seq;
                        r_highest <= r_item.next_tx_seq;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.alpha_fin) begin
                r_alpha <= alpha_n;
            end
            // Hold result until taken, load a new one when free
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_upd      <= need_alpha;
            r_rem      <= {1'b0, mk_n};
            r_dvs      <= dvs_n;
            r_frac_sat <= mk_n >= dvs_n;
            r_q        <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? (rem2 - {1'b0, r_dvs}) : rem2;
            r_q   <= {r_q[14:0], ge};
        end
        if (i_cmd.mul_a || i_cmd.mul_b || i_cmd.ss_mul) begin
            r_prod <= {32'd0, mul_x} * {17'd0, mul_y};
        end
        if (i_cmd.mul_b) begin
            r_acc <= r_prod[33:0];
        end
        if (i_cmd.ss_fin) begin
            r_ss <= (wnd > flo) ? wnd : flo;
        end
        if (i_cmd.out_load) begin
            r_out.alpha_out     <= r_alpha;
            r_out.ssthresh_out  <= r_ss;
            r_out.alpha_updated <= r_upd;
        end
    end

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha <= ONE)
        else $error("alpha above one");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !r_frac_sat) |-> (r_rem < {1'b0, r_dvs}))
        else $error("divider remainder not below divisor");

endmodule

// File: sv/dctcp_alpha_estimator_core.sv
// Top level of the DCTCP alpha estimator: controller plus datapath.
// Depends on dae_pkg, dae_ctrl and dae_dpath.
//
// Use: events enter on the input channel (i_in_valid / o_in_ready) as one
// t_in_item; every event yields exactly one t_out_item on the output channel
// (o_out_valid / i_out_ready) carrying alpha, ssthresh and the update flag.
// Configuration (EWMA gain, MSS) is written on the cfg channel, index 0 or
// 1; o_cfg_ready is always high and writes take effect the next cycle.
// Each event is evaluated; an ACK that crosses the barrier then runs the
// restoring divider, two products on the shared 17x32 multiplier and the
// alpha blend; every event then forms the ssthresh product and its floor.
// One event is in work at a time; the next is accepted the cycle after the
// result is loaded into the output register, which happens only when that
// register is free. A stalled receiver holds back at most one event beyond
// the one waiting there.
// Reset (synchronous, active low) sets alpha to 1.0, clears the counters
// and sequence marks, and restores gain 4096 and MSS 536.
module dctcp_alpha_estimator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dae_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dae_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dae_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dae_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    dae_pkg::t_cmd cmd;
    dae_pkg::t_sts sts;

    // Config writes are taken at once
    assign o_cfg_ready = 1'b1;

    dae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    dae_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dctcp_alpha_estimator_core: TCP-like event streams and
// an alpha/ssthresh predictor checked in order against every result item.
// Depends on dae_pkg and the core RTL; needs no files or arguments.
module tb;

    localparam int          RESET_CYCLES  = 9;
    localparam int          PHASES        = 6;
    localparam int          PHASE_EVENTS  = 175;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_EVENTS   = 12;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          MAX_PRINTS    = 40;
    localparam logic [63:0] Q16_ONE       = 64'd65536;

    // Predicts alpha/ssthresh per event and checks results against the queue
    class alpha_tracker;
        logic [16:0]        gain;
        logic [15:0]        mss;
        logic [16:0]        alpha;
        logic [31:0]        marked;
        logic [31:0]        total;
        logic [31:0]        barrier;
        logic [31:0]        highest;
        dae_pkg::t_out_item expected_q[$];
        int                 errors;

        function new();
            gain    = 17'd4096;
            mss     = 16'd536;
            alpha   = 17'd65536;
            marked  = '0;
            total   = '0;
            barrier = '0;
            highest = '0;
            errors  = 0;
        endfunction

        // a is later than b in wrapping sequence space
        function bit later_than(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return (d != 32'd0) && (d < 32'h8000_0000);
        endfunction

        function logic [31:0] seq_latest(logic [31:0] a, logic [31:0] b);
            return later_than(b, a) ? b : a;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // EWMA of the marked fraction, rounded to nearest
        function void update_alpha();
            logic [63:0] g;
            logic [63:0] tot;
            logic [63:0] frac;
            logic [63:0] acc;
            g    = (64'(gain) > Q16_ONE) ? Q16_ONE : 64'(gain);
            tot  = (total == 32'd0) ? 64'd1 : 64'(total);
            frac = 64'({marked, 16'h0000}) / tot;
            if (frac > Q16_ONE) begin
                frac = Q16_ONE;
            end
            acc = ((Q16_ONE - g) * 64'(alpha) + g * frac + 64'd32768) >> 16;
            alpha = (acc > Q16_ONE) ? 17'd65536 : acc[16:0];
        endfunction

        function logic [31:0] ssthresh_for(logic [31:0] cwnd);
            logic [63:0] red;
            logic [63:0] wnd;
            logic [63:0] flo;
            red = (64'(alpha) * 64'(cwnd) + 64'd131071) >> 17;
            wnd = 64'(cwnd) - red;
            flo = 64'(mss) << 1;
            return (wnd > flo) ? wnd[31:0] : flo[31:0];
        endfunction

        function void set_reg(logic [dae_pkg::CFG_IDX_W-1:0] idx,
                              logic [dae_pkg::CFG_DATA_W-1:0] data);
            if (idx == dae_pkg::CFG_EWMA_WEIGHT) begin
                gain = data;
            end else if (idx == dae_pkg::CFG_MSS) begin
                mss = data[15:0];
            end
        endfunction

        // Advance the state for one accepted event and queue its result
        function void note_event(dae_pkg::t_in_item it);
            logic [31:0]        d;
            dae_pkg::t_out_item res;
            res.alpha_updated = 1'b0;
            case (it.op)
                dae_pkg::OP_ACK: begin
                    if (!it.syn_flag) begin
                        d = it.ack_number - it.prior_ack_mark;
                        if (d != 32'd0 && d < 32'h8000_0000) begin
                            total = add_sat(total, d);
                            if (it.ece_flag) begin
                                marked = add_sat(marked, d);
                            end
                        end
                        if (later_than(it.ack_number, barrier)) begin
                            barrier = highest;
                            update_alpha();
                            marked = '0;
                            total  = '0;
                            res.alpha_updated = 1'b1;
                        end
                    end
                end
                dae_pkg::OP_SENT: begin
                    highest = seq_latest(seq_latest(it.segment_seq + 32'(it.segment_bytes),
                                                    it.high_tx_mark), highest);
                end
                dae_pkg::OP_RETX: begin
                    barrier = it.next_tx_seq;
                    highest = it.next_tx_seq;
                end
                default: begin
                end
            endcase
            res.alpha_out    = alpha;
            res.ssthresh_out = ssthresh_for(it.cwnd_bytes);
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("%0t MISMATCH %s: got %0h expected %0h", $time, what, got, want);
            end
        endtask

        // Compare one result item with the oldest prediction
        task check_result(dae_pkg::t_out_item got);
            dae_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(got.alpha_out), '0);
            end else begin
                want = expected_q.pop_front();
                if (got.alpha_out !== want.alpha_out) begin
                    report_mismatch("alpha_out", 32'(got.alpha_out), 32'(want.alpha_out));
                end
                if (got.ssthresh_out !== want.ssthresh_out) begin
                    report_mismatch("ssthresh_out", got.ssthresh_out, want.ssthresh_out);
                end
                if (got.alpha_updated !== want.alpha_updated) begin
                    report_mismatch("alpha_updated", 32'(got.alpha_updated),
                                    32'(want.alpha_updated));
                end
            end
        endtask
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    dae_pkg::t_in_item              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    dae_pkg::t_out_item             o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [dae_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dae_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    alpha_tracker tracker;
    int           idle_cycles     = 0;
    int           send_idle_pct   = 0;
    int           recv_stall_pct  = 0;
    int           ece_pct         = 30;
    logic         rx_hold         = 1'b0;
    logic [31:0]  tx_una;
    logic [31:0]  tx_nxt;

    logic [16:0] gain_set [PHASES] = '{17'd65536, 17'd0, 17'h1FFFF, 17'd16, 17'd0, 17'd4096};
    logic [15:0] mss_set  [PHASES] = '{16'd1460, 16'd65535, 16'd0, 16'd1, 16'd0, 16'd536};
    int          ece_set  [PHASES] = '{30, 100, 0, 50, 10, 70};

    dctcp_alpha_estimator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off while rx_hold is set
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Observe handshakes at each edge: results first, then events and writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                tracker.check_result(o_out_data);
            end
            if (i_in_valid && o_in_ready) begin
                tracker.note_event(i_in_data);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_reg(i_cfg_index, i_cfg_data);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("dctcp_alpha_estimator_core test failed");
        $finish;
    end

    function automatic logic [31:0] pick_cwnd();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(2000000, 1000));
        endcase
    endfunction

    // Fully random event of a legal kind
    function automatic dae_pkg::t_in_item noise_event();
        dae_pkg::t_in_item it;
        it.op             = dae_pkg::t_op'($urandom_range(2));
        it.ack_number     = $urandom;
        it.prior_ack_mark = $urandom;
        it.ece_flag       = 1'($urandom);
        it.syn_flag       = 1'($urandom);
        it.segment_seq    = $urandom;
        it.segment_bytes  = 16'($urandom);
        it.high_tx_mark   = $urandom;
        it.next_tx_seq    = $urandom;
        it.cwnd_bytes     = pick_cwnd();
        return it;
    endfunction

    function automatic dae_pkg::t_in_item ack_event(logic [31:0] ack, logic [31:0] prior,
                                                    logic ece, logic syn);
        dae_pkg::t_in_item it;
        it                = noise_event();
        it.op             = dae_pkg::OP_ACK;
        it.ack_number     = ack;
        it.prior_ack_mark = prior;
        it.ece_flag       = ece;
        it.syn_flag       = syn;
        return it;
    endfunction

    function automatic dae_pkg::t_in_item sent_event(logic [31:0] seq, logic [15:0] len,
                                                     logic [31:0] htx);
        dae_pkg::t_in_item it;
        it               = noise_event();
        it.op            = dae_pkg::OP_SENT;
        it.segment_seq   = seq;
        it.segment_bytes = len;
        it.high_tx_mark  = htx;
        return it;
    endfunction

    function automatic dae_pkg::t_in_item retx_event(logic [31:0] ntx);
        dae_pkg::t_in_item it;
        it             = noise_event();
        it.op          = dae_pkg::OP_RETX;
        it.next_tx_seq = ntx;
        return it;
    endfunction

    // Next event of a sender/receiver exchange, with some noise mixed in
    task automatic make_random_event(output dae_pkg::t_in_item it);
        int unsigned pick;
        int unsigned r;
        logic [31:0] inflight;
        logic [31:0] adv;
        logic [15:0] len;
        pick = $urandom_range(99);
        if (pick < 12) begin
            it = noise_event();
        end else if (pick < 50) begin
            r   = $urandom_range(99);
            len = (r < 4) ? 16'd0 : (r < 8) ? 16'hFFFF : 16'($urandom_range(1460, 1));
            if ($urandom_range(1) == 0) begin
                it = sent_event(tx_nxt, len, tx_nxt);
            end else begin
                it = sent_event(tx_nxt, len, tx_nxt + 32'($urandom_range(32'(len))));
            end
            tx_nxt += 32'(len);
        end else if (pick < 92) begin
            inflight = tx_nxt - tx_una;
            if (inflight[31]) begin
                inflight = '0;
            end
            if ($urandom_range(99) < 5) begin
                // stale ack behind the prior mark
                it = ack_event(tx_una - 32'($urandom_range(3000, 1)), tx_una,
                               1'($urandom_range(99) < ece_pct), 1'b0);
            end else begin
                adv = $urandom_range(inflight);
                it  = ack_event(tx_una + adv, tx_una, 1'($urandom_range(99) < ece_pct),
                                1'($urandom_range(99) < 3));
                tx_una += adv;
            end
        end else begin
            it     = retx_event(tx_una);
            tx_nxt = tx_una;
        end
    endtask

    // Offer one item and hold it until accepted
    task automatic send_event(input dae_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every pending result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [dae_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dae_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        dae_pkg::t_in_item ev;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: SYN ack skips bookkeeping
        send_event(ack_event(32'd100, 32'd0, 1'b1, 1'b1));
        ev = sent_event(32'd0, 16'd1000, 32'd0);
        ev.cwnd_bytes = 32'd0;
        send_event(ev);
        // zero-length segment with a stale high mark leaves highest_sent alone
        ev = sent_event(32'd1000, 16'd0, 32'd500);
        ev.cwnd_bytes = 32'hFFFF_FFFF;
        send_event(ev);
        // first barrier crossing with marked bytes
        ev = ack_event(32'd500, 32'd0, 1'b1, 1'b0);
        ev.cwnd_bytes = 32'hFFFF_FFFF;
        send_event(ev);
        // ack equal to the barrier does not update
        send_event(ack_event(32'd1000, 32'd500, 1'b0, 1'b0));
        // ack going backward counts nothing
        send_event(ack_event(32'd800, 32'd1000, 1'b1, 1'b0));
        // difference of exactly half the space is not after
        send_event(ack_event(32'h8000_03E8, 32'h0000_03E8, 1'b1, 1'b0));
        // unknown event kind leaves the state unchanged
        ev = noise_event();
        ev.op = dae_pkg::t_op'(2'd3);
        send_event(ev);
        send_event(ack_event(32'd1001, 32'd1000, 1'b0, 1'b0));
        // sequence wrap through retransmit, send and ack
        send_event(retx_event(32'hFFFF_FF00));
        send_event(sent_event(32'hFFFF_FF00, 16'h0200, 32'hFFFF_FF00));
        send_event(ack_event(32'h0000_0080, 32'hFFFF_FF00, 1'b1, 1'b0));
        // saturate both byte counters below the barrier, then cross it
        send_event(retx_event(32'h8000_0000));
        repeat (3) send_event(ack_event(32'h7FFF_FFFF, 32'd0, 1'b1, 1'b0));
        send_event(ack_event(32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0));
        send_event(ack_event(32'h8000_0001, 32'h8000_0000, 1'b1, 1'b0));
        // crossing with no acked bytes at all
        send_event(retx_event(32'd100));
        send_event(ack_event(32'd200, 32'd200, 1'b0, 1'b0));
        send_event(ack_event(32'h0000_9000, 32'd0, 1'b1, 1'b1));
        send_event(sent_event(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));

        // Random phases, each with its own settings and one of four idling patterns
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 4) begin
                gain_set[p] = 17'($urandom_range(65536));
                mss_set[p]  = 16'($urandom_range(65535, 1));
            end
            write_reg(dae_pkg::CFG_EWMA_WEIGHT, gain_set[p]);
            write_reg(dae_pkg::CFG_MSS, {1'b0, mss_set[p]});
            ece_pct = ece_set[p];
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            tx_una = (p % 2 == 1) ? 32'hFFFF_FFFF - 32'($urandom_range(20000)) : $urandom;
            tx_nxt = tx_una;
            send_event(retx_event(tx_una));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (p == 2 && n == PHASE_EVENTS / 2) begin
                    // hold the receiver off while events keep coming
                    fork
                        begin
                            rx_hold <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge i_clk);
                            rx_hold <= 1'b0;
                        end
                    join_none
                    for (int k = 0; k < HOLD_EVENTS; k++) begin
                        make_random_event(ev);
                        send_event(ev);
                    end
                    drain();
                end
                make_random_event(ev);
                send_event(ev);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
            $display("dctcp_alpha_estimator_core test passed");
        end else begin
            $display("dctcp_alpha_estimator_core test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/dae_pkg.sv
sv/dae_ctrl.sv
sv/dae_dpath.sv
sv/dctcp_alpha_estimator_core.sv
sim/tb.sv
